// File: sv/pfd_pkg.sv
package pfd_pkg;

  localparam int DEFAULT_DEPTH      = 16;
  localparam int DEFAULT_ITEM_WIDTH = 16;
  localparam int MAX_RESULTS        = 16;
  localparam int DRAIN_CW           = $clog2(MAX_RESULTS);

  localparam int OPCODE_W   = 2;
  localparam int PAYLOAD_W  = 16;
  localparam int POSITION_W = 5;
  localparam int ITEM_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // what a slot cell does on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_cmd_t;

endpackage

// File: sv/pfd_cell.sv
module pfd_cell #(
  parameter int ITEM_WIDTH = pfd_pkg::DEFAULT_ITEM_WIDTH
) (
  input  logic                  clk,
  input  pfd_pkg::cell_cmd_t    cmd,
  input  logic [ITEM_WIDTH-1:0] load_data,
  input  logic [ITEM_WIDTH-1:0] left_data,
  input  logic [ITEM_WIDTH-1:0] right_data,
  output logic [ITEM_WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    case (cmd)
      pfd_pkg::CELL_LOAD:       data <= load_data;
      pfd_pkg::CELL_FROM_LEFT:  data <= left_data;
      pfd_pkg::CELL_FROM_RIGHT: data <= right_data;
      default:                  data <= data;
    endcase
  end

endmodule

// File: sv/priority_front_deque.sv
// Bounded deque of handles held in a row of slot cells, head in cell 0. Add, remove and
// pop each give a single result word (last high): start is taken whenever busy is low,
// and the word appears on the cycle after the start, marked by done. A drain of N held
// entries gives min(N, 16) result words, one cell shift per cycle, one result word per cycle
// starting the cycle after the start; busy is high while every drain word after the first
// is formed, through the cycle that forms the last word, and drops as that word appears
// on the outputs, so a new start can be taken in that cycle. An empty drain gives a single
// word. The receiver cannot stall: each word is valid on item/status/occupancy/last in the
// cycle in which done is high for it.
module priority_front_deque #(
  parameter int DEPTH      = pfd_pkg::DEFAULT_DEPTH,
  parameter int ITEM_WIDTH = pfd_pkg::DEFAULT_ITEM_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pfd_pkg::OPCODE_W-1:0]     opcode,
  input  logic [pfd_pkg::PAYLOAD_W-1:0]    payload,
  input  logic                             high_priority,
  input  logic [pfd_pkg::POSITION_W-1:0]   position,
  output logic                             done,
  output logic [pfd_pkg::ITEM_W-1:0]       item,
  output logic [pfd_pkg::STATUS_W-1:0]     status,
  output logic [pfd_pkg::OCC_W-1:0]        occupancy,
  output logic                             last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = 8;

  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic                           draining;
  logic [pfd_pkg::DRAIN_CW-1:0]   drain_cnt;
  logic [pfd_pkg::DRAIN_CW-1:0]   drain_cnt_next;

  logic [ITEM_WIDTH-1:0]          slot [DEPTH];
  logic [ITEM_WIDTH-1:0]          load_word;
  logic [ITEM_WIDTH-1:0]          taken;

  logic                           accept;
  logic                           empty;
  logic                           full;
  logic [PW-1:0]                  pos_w;
  logic [PW-1:0]                  cnt_w;

  logic                           ins_head;
  logic                           ins_tail;
  logic                           take;
  logic                           drain_step;
  logic                           emit;
  logic [IW-1:0]                  idx;
  pfd_pkg::status_t               res_status;
  logic                           res_last;

  assign accept    = start && !draining;
  assign busy      = draining;
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign pos_w     = PW'(position);
  assign cnt_w     = PW'(count);
  assign load_word = ITEM_WIDTH'(payload);

  always_comb begin
    ins_head   = 1'b0;
    ins_tail   = 1'b0;
    take       = 1'b0;
    drain_step = 1'b0;
    emit       = 1'b0;
    idx        = '0;
    res_status = pfd_pkg::ST_OK;
    res_last   = 1'b1;
    if (draining) begin
      emit       = 1'b1;
      take       = 1'b1;
      drain_step = 1'b1;
      res_last   = (count == CW'(1)) ||
                   (drain_cnt == pfd_pkg::DRAIN_CW'(pfd_pkg::MAX_RESULTS - 1));
    end else if (accept) begin
      emit = 1'b1;
      case (pfd_pkg::op_t'(opcode))
        pfd_pkg::OP_ADD: begin
          if (full) begin
            res_status = pfd_pkg::ST_FULL;
          end else if (high_priority) begin
            ins_head = 1'b1;
          end else begin
            ins_tail = 1'b1;
          end
        end
        pfd_pkg::OP_REMOVE: begin
          if (empty) begin
            res_status = pfd_pkg::ST_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            res_status = pfd_pkg::ST_BAD_POS;
          end else begin
            take = 1'b1;
            idx  = IW'(pos_w - PW'(1));
          end
        end
        pfd_pkg::OP_POP: begin
          if (empty) begin
            res_status = pfd_pkg::ST_EMPTY;
          end else begin
            take = 1'b1;
          end
        end
        pfd_pkg::OP_DRAIN: begin
          if (empty) begin
            res_status = pfd_pkg::ST_EMPTY;
          end else begin
            take       = 1'b1;
            drain_step = 1'b1;
            res_last   = (count == CW'(1));
          end
        end
        default: ;
      endcase
    end
  end

  // word leaving the chain at the take index
  always_comb begin
    taken = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IW'(i) == idx) taken = taken | slot[i];
    end
  end

  always_comb begin
    count_next = count;
    if (ins_head || ins_tail) count_next = count + CW'(1);
    else if (take)            count_next = count - CW'(1);
  end

  always_comb begin
    drain_cnt_next = '0;
    if (drain_step && !res_last) begin
      drain_cnt_next = draining ? drain_cnt + pfd_pkg::DRAIN_CW'(1)
                                : pfd_pkg::DRAIN_CW'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pfd_pkg::cell_cmd_t    cmd;
    logic [ITEM_WIDTH-1:0] left_data;
    logic [ITEM_WIDTH-1:0] right_data;

    always_comb begin
      cmd = pfd_pkg::CELL_HOLD;
      if (ins_head) begin
        cmd = (g == 0) ? pfd_pkg::CELL_LOAD : pfd_pkg::CELL_FROM_LEFT;
      end else if (ins_tail && count == CW'(g)) begin
        cmd = pfd_pkg::CELL_LOAD;
      end else if (take && IW'(g) >= idx) begin
        cmd = pfd_pkg::CELL_FROM_RIGHT;
      end
    end

    if (g == 0) begin : g_head
      assign left_data = slot[g];
    end else begin : g_mid
      assign left_data = slot[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_data = slot[g];
    end else begin : g_body
      assign right_data = slot[g+1];
    end

    pfd_cell #(
      .ITEM_WIDTH(ITEM_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .load_data (load_word),
      .left_data (left_data),
      .right_data(right_data),
      .data      (slot[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      draining  <= 1'b0;
      drain_cnt <= '0;
      done      <= 1'b0;
    end else begin
      count     <= count_next;
      draining  <= drain_step && !res_last;
      drain_cnt <= drain_cnt_next;
      done      <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item      <= take ? pfd_pkg::ITEM_W'(taken) : '0;
      status    <= res_status;
      occupancy <= pfd_pkg::OCC_W'(count_next);
      last      <= res_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_drain_contiguous: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done)
    else $error("gap inside a drain burst");

  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done && last)
    else $error("drain ended without a last word");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    done && status == pfd_pkg::ST_FULL |-> occupancy == pfd_pkg::OCC_W'(DEPTH))
    else $error("full refusal while not full");

endmodule
